/* hdl/svfbp_pkg.sv */
`default_nettype none
package svfbp_pkg;

  localparam int FW = 16;
  localparam int QW = 16;
  localparam int SRW = 18;
  localparam int CW = 32;
  localparam int DIVW = 41;
  localparam int XYW = 34;
  localparam int IW = 5;
  localparam int QDEPTH = 2;
  localparam int QAW = 1;

  localparam logic [SRW-1:0] SR_RESET = 18'd48000;
  localparam logic [FW-1:0] MIN_FREQ = 16'd20;
  localparam logic [QW-1:0] MIN_Q = 16'd128;
  localparam logic [CW-1:0] PHASE_049 = 32'd2104533975;
  localparam logic [CW-1:0] PI_Q30 = 32'd3373259426;
  localparam logic [CW-1:0] COEF_MAX = 32'h8000_0000;
  localparam logic [CW-1:0] GAIN_MAX = 32'hFFFF_FFFF;
  // upper words of 2^38 and 2^55 for the long divisions
  localparam logic [DIVW-1:0] K_NUM_HI = 41'd64;
  localparam logic [DIVW-1:0] A1_NUM_HI = 41'd8388608;
  localparam logic [DIVW-1:0] ONE_Q24 = 41'd16777216;
  localparam logic signed [XYW-1:0] ONE_Q30 = 34'sd1073741824;

  typedef struct packed {
    logic [FW-1:0]  freq;
    logic [QW-1:0]  q;
    logic [SRW-1:0] sr;
    logic           sr_zero;
    logic           phase_clamp;
  } item_t;

  typedef struct packed {
    logic            start;
    logic [DIVW-1:0] hi;
    logic [CW-1:0]   low;
    logic [DIVW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic          busy;
    logic          done;
    logic [CW-1:0] quot;
  } div_rsp_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_KDIV,
    ST_KWAIT,
    ST_XDIV,
    ST_XWAIT,
    ST_THETA,
    ST_CORDIC,
    ST_GSEL,
    ST_GWAIT,
    ST_PMUL,
    ST_PSUM,
    ST_A1DIV,
    ST_A1WAIT,
    ST_A2MUL,
    ST_A2SAT,
    ST_A3MUL,
    ST_A3SAT,
    ST_DONE
  } state_t;

  function automatic logic [CW-1:0] atan_q30(input logic [IW-1:0] i);
    logic [CW-1:0] v;
    case (i)
      5'd0:  v = 32'h3243F6A8;
      5'd1:  v = 32'h1DAC6705;
      5'd2:  v = 32'h0FADBAFC;
      5'd3:  v = 32'h07F56EA6;
      5'd4:  v = 32'h03FEAB76;
      5'd5:  v = 32'h01FFD55B;
      5'd6:  v = 32'h00FFFAAA;
      5'd7:  v = 32'h007FFF55;
      5'd8:  v = 32'h003FFFEA;
      5'd9:  v = 32'h001FFFFD;
      5'd10: v = 32'h000FFFFF;
      5'd11: v = 32'h0007FFFF;
      5'd12: v = 32'h0003FFFF;
      5'd13: v = 32'h0001FFFF;
      5'd14: v = 32'h0000FFFF;
      5'd15: v = 32'h00007FFF;
      5'd16: v = 32'h00003FFF;
      5'd17: v = 32'h00001FFF;
      5'd18: v = 32'h00000FFF;
      5'd19: v = 32'h000007FF;
      5'd20: v = 32'h000003FF;
      5'd21: v = 32'h000001FF;
      5'd22: v = 32'h000000FF;
      5'd23: v = 32'h0000007F;
      5'd24: v = 32'h0000003F;
      5'd25: v = 32'h0000001F;
      5'd26: v = 32'h0000000F;
      5'd27: v = 32'h00000008;
      5'd28: v = 32'h00000004;
      5'd29: v = 32'h00000002;
      5'd30: v = 32'h00000001;
      default: v = 32'h00000000;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

/* hdl/svfbp_front.sv */
`default_nettype none
module svfbp_front (
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [15:0]              centre_freq_hz,
  input  logic [15:0]              quality,
  input  logic [17:0]              sr,
  input  logic                     q_full,
  output logic                     q_push,
  output svfbp_pkg::item_t         q_item
);
  import svfbp_pkg::*;

  logic [FW-1:0] f_cl;
  logic [QW-1:0] q_cl;
  logic [23:0]   f_x100;
  logic [23:0]   sr_x49;

  assign f_cl = (centre_freq_hz < MIN_FREQ) ? MIN_FREQ : centre_freq_hz;
  assign q_cl = (quality < MIN_Q) ? MIN_Q : quality;
  // limit at 0.49 of the sample rate
  assign f_x100 = 24'(f_cl) * 24'd100;
  assign sr_x49 = 24'(sr) * 24'd49;

  assign in_ready = !q_full;
  assign q_push = in_valid && !q_full;

  always_comb begin
    q_item.freq = f_cl;
    q_item.q = q_cl;
    q_item.sr = sr;
    q_item.sr_zero = (sr == '0);
    q_item.phase_clamp = (f_x100 > sr_x49);
  end

endmodule
`default_nettype wire

/* hdl/svfbp_fifo.sv */
`default_nettype none
module svfbp_fifo (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  svfbp_pkg::item_t  push_item,
  output logic              full,
  input  logic              pop,
  output logic              head_valid,
  output svfbp_pkg::item_t  head_item
);
  import svfbp_pkg::*;

  item_t          entries [QDEPTH];
  logic [QAW-1:0] wr_ptr;
  logic [QAW-1:0] rd_ptr;
  logic [QAW:0]   count;

  assign full = (count == (QAW+1)'(QDEPTH));
  assign head_valid = (count != '0);
  assign head_item = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop) count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_item;
  end

endmodule
`default_nettype wire

/* hdl/svfbp_div.sv */
`default_nettype none
module svfbp_div (
  input  logic                 clk,
  input  logic                 rst,
  input  svfbp_pkg::div_req_t  req,
  output svfbp_pkg::div_rsp_t  rsp
);
  import svfbp_pkg::*;

  logic [DIVW-1:0] rem;
  logic [DIVW-1:0] divisor;
  logic [CW-1:0]   low;
  logic [CW-1:0]   quot;
  logic [IW-1:0]   cnt;
  logic            busy;
  logic            done;
  logic [DIVW:0]   trial;
  logic            ge;

  // restoring division, one quotient bit a cycle; hi must be below divisor
  assign trial = {rem, low[CW-1]};
  assign ge = (trial >= {1'b0, divisor});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == '1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= req.hi;
      low <= req.low;
      divisor <= req.divisor;
      quot <= '0;
    end else if (busy) begin
      rem <= ge ? DIVW'(trial - {1'b0, divisor}) : trial[DIVW-1:0];
      low <= {low[CW-2:0], 1'b0};
      quot <= {quot[CW-2:0], ge};
    end
  end

  assign rsp.busy = busy;
  assign rsp.done = done;
  assign rsp.quot = quot;

endmodule
`default_nettype wire

/* hdl/svfbp_back.sv */
`default_nettype none
module svfbp_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_valid,
  input  svfbp_pkg::item_t  q_item,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [31:0]       warp_gain,
  output logic [31:0]       damping,
  output logic [31:0]       coef_one,
  output logic [31:0]       coef_two,
  output logic [31:0]       coef_three
);
  import svfbp_pkg::*;

  state_t state;
  state_t state_next;

  item_t                  item;
  logic [CW-1:0]          k;
  logic [CW-1:0]          x;
  logic [CW-1:0]          g;
  logic [CW-1:0]          a1;
  logic [CW-1:0]          a2;
  logic [CW-1:0]          a3;
  logic signed [XYW-1:0]  cx;
  logic signed [XYW-1:0]  cy;
  logic signed [XYW-1:0]  z;
  logic [IW-1:0]          iter;
  logic [40:0]            pa;
  logic [55:0]            pb;
  logic [DIVW-1:0]        dv;
  logic [63:0]            prod;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic signed [XYW-1:0] dx;
  logic signed [XYW-1:0] dy;
  logic signed [XYW-1:0] atn;
  logic                  cy_pos;
  logic                  cx_pos;
  logic                  g_sat;
  logic                  g_div;
  logic                  x_div;
  logic [32:0]           s;
  logic                  res_load;

  svfbp_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  assign dx = cy >>> iter;
  assign dy = cx >>> iter;
  assign atn = $signed({2'b00, atan_q30(iter)});
  assign cy_pos = !cy[XYW-1] && (cy != '0);
  assign cx_pos = !cx[XYW-1] && (cx != '0);
  // quotient would reach 2^32
  assign g_sat = ({8'd0, cy[XYW-1:0]} >= {cx[XYW-1:0], 8'd0});
  assign g_div = cy_pos && cx_pos && !g_sat;
  assign x_div = !item.sr_zero && !item.phase_clamp;
  assign s = {1'b0, g} + 33'(k >> 6);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (q_valid) state_next = ST_KDIV;
      ST_KDIV:   state_next = ST_KWAIT;
      ST_KWAIT:  if (div_rsp.done) state_next = ST_XDIV;
      ST_XDIV: begin
        if (item.sr_zero) state_next = ST_PMUL;
        else if (item.phase_clamp) state_next = ST_THETA;
        else state_next = ST_XWAIT;
      end
      ST_XWAIT:  if (div_rsp.done) state_next = ST_THETA;
      ST_THETA:  state_next = ST_CORDIC;
      ST_CORDIC: if (iter == '1) state_next = ST_GSEL;
      ST_GSEL:   state_next = g_div ? ST_GWAIT : ST_PMUL;
      ST_GWAIT:  if (div_rsp.done) state_next = ST_PMUL;
      ST_PMUL:   state_next = ST_PSUM;
      ST_PSUM:   state_next = ST_A1DIV;
      ST_A1DIV:  state_next = ST_A1WAIT;
      ST_A1WAIT: if (div_rsp.done) state_next = ST_A2MUL;
      ST_A2MUL:  state_next = ST_A2SAT;
      ST_A2SAT:  state_next = ST_A3MUL;
      ST_A3MUL:  state_next = ST_A3SAT;
      ST_A3SAT:  state_next = ST_DONE;
      ST_DONE:   if (!out_valid || out_ready) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    div_req = '0;
    q_pop = 1'b0;
    res_load = 1'b0;
    unique case (state)
      ST_IDLE: q_pop = q_valid;
      ST_KDIV: begin
        div_req.start = 1'b1;
        div_req.hi = K_NUM_HI;
        div_req.divisor = DIVW'(item.q);
      end
      ST_XDIV: begin
        div_req.start = x_div;
        div_req.hi = DIVW'(item.freq);
        div_req.divisor = DIVW'(item.sr);
      end
      ST_GSEL: begin
        div_req.start = g_div;
        div_req.hi = DIVW'(cy[XYW-1:8]);
        div_req.low = {cy[7:0], 24'd0};
        div_req.divisor = DIVW'(cx[XYW-1:0]);
      end
      ST_A1DIV: begin
        div_req.start = 1'b1;
        div_req.hi = A1_NUM_HI;
        div_req.divisor = dv;
      end
      ST_DONE: res_load = !out_valid || out_ready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: if (q_valid) item <= q_item;
      ST_KWAIT: if (div_rsp.done) k <= div_rsp.quot;
      ST_XDIV: begin
        g <= '0;
        x <= PHASE_049;
      end
      ST_XWAIT: if (div_rsp.done) x <= div_rsp.quot;
      ST_THETA: begin
        prod <= 64'(x) * 64'(PI_Q30);
        cx <= ONE_Q30;
        cy <= '0;
        iter <= '0;
      end
      ST_CORDIC: begin
        if (iter == '0) begin
          // first step uses the fresh phase product
          if (!prod[63]) begin
            cx <= cx - dx;
            cy <= cy + dy;
            z <= $signed({2'b00, prod[63:32]}) - atn;
          end else begin
            cx <= cx + dx;
            cy <= cy - dy;
            z <= $signed({2'b00, prod[63:32]}) + atn;
          end
        end else if (!z[XYW-1]) begin
          cx <= cx - dx;
          cy <= cy + dy;
          z <= z - atn;
        end else begin
          cx <= cx + dx;
          cy <= cy - dy;
          z <= z + atn;
        end
        iter <= iter + 1'b1;
      end
      ST_GSEL: begin
        if (!cy_pos) g <= '0;
        else if (!cx_pos || g_sat) g <= GAIN_MAX;
      end
      ST_GWAIT: if (div_rsp.done) g <= div_rsp.quot;
      ST_PMUL: begin
        pa <= 41'(g) * 41'(s[32:24]);
        pb <= 56'(g) * 56'(s[23:0]);
      end
      ST_PSUM: dv <= DIVW'(42'(ONE_Q24) + 42'(pa) + 42'(pb[55:24]));
      ST_A1WAIT: if (div_rsp.done) a1 <= div_rsp.quot;
      ST_A2MUL: prod <= 64'(g) * 64'(a1);
      ST_A2SAT: a2 <= (prod[63:24] > 40'(COEF_MAX)) ? COEF_MAX : prod[55:24];
      ST_A3MUL: prod <= 64'(g) * 64'(a2);
      ST_A3SAT: a3 <= (prod[63:24] > 40'(COEF_MAX)) ? COEF_MAX : prod[55:24];
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (res_load) out_valid <= 1'b1;
    else if (out_ready) out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      warp_gain <= g;
      damping <= k;
      coef_one <= a1;
      coef_two <= a2;
      coef_three <= a3;
    end
  end

  a_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> (state == ST_KWAIT || state == ST_XWAIT ||
                      state == ST_GWAIT || state == ST_A1WAIT))
    else $error("divider finished outside a wait state");

  a_start_idle_div: assert property (@(posedge clk) disable iff (rst)
    div_req.start |-> !div_rsp.busy)
    else $error("divider started while busy");

  a_coef_limit: assert property (@(posedge clk) disable iff (rst)
    (state == ST_A3SAT) |=> (a2 <= COEF_MAX) && (a3 <= COEF_MAX))
    else $error("coefficient above unity");

  a_pop_only_idle: assert property (@(posedge clk) disable iff (rst)
    q_pop |=> (state == ST_KDIV))
    else $error("item popped without starting work");

endmodule
`default_nettype wire

/* hdl/svf_bandpass_coefficients.sv */
// Bandpass SVF coefficient generator: each item (centre frequency in Hz, Q in
// unsigned 8.8) yields g = tan(pi*fc/sr) in Q8.24, k = 1/Q in Q2.30 and a1, a2,
// a3 in Q1.31. An item takes less time when the frequency hits the 0.49*sr
// limit and less again when the sample rate is zero, as steps are skipped;
// the time is set by one shared restoring divider, one quotient bit a cycle,
// used up to four times per item, plus a 32-step CORDIC for the tangent. A
// two-entry queue in front lets new items be taken while one is in work and a
// finished result waits in the output register. The sample rate register
// resets to 48000 and should only be written while the block is idle.
`default_nettype none
module svf_bandpass_coefficients (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [17:0] sample_rate_hz,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] centre_freq_hz,
  input  logic [15:0] quality,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] warp_gain,
  output logic [31:0] damping,
  output logic [31:0] coef_one,
  output logic [31:0] coef_two,
  output logic [31:0] coef_three
);
  import svfbp_pkg::*;

  logic [SRW-1:0] sr;
  logic           q_full;
  logic           q_push;
  logic           q_pop;
  logic           q_valid;
  item_t          push_item;
  item_t          head_item;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) sr <= SR_RESET;
    else if (cfg_valid) sr <= sample_rate_hz;
  end

  svfbp_front u_front (
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .centre_freq_hz (centre_freq_hz),
    .quality        (quality),
    .sr             (sr),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_item         (push_item)
  );

  svfbp_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_item  (push_item),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_item  (head_item)
  );

  svfbp_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_valid),
    .q_item     (head_item),
    .q_pop      (q_pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .warp_gain  (warp_gain),
    .damping    (damping),
    .coef_one   (coef_one),
    .coef_two   (coef_two),
    .coef_three (coef_three)
  );

endmodule
`default_nettype wire
